// File: hdl/assert_macros.svh
// Assertion macros for the positional insert/delete list.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define PLID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define PLID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/plid_pkg.sv
// Shared types, codes and constants for the positional insert/delete list.
// No dependencies; imported by every module of the block.
package plid_pkg;

  localparam int DepthDef   = 16;
  localparam int MaxResults = 16;

  // command kinds
  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_DELETE   = 2'd1;
  localparam logic [1:0] KIND_TRAVERSE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_BADPOS = 3'd3;
  localparam logic [2:0] ST_ELEM   = 3'd4;

  // cell array operations
  localparam logic [1:0] CELL_NOP = 2'd0;
  localparam logic [1:0] CELL_INS = 2'd1;
  localparam logic [1:0] CELL_DEL = 2'd2;
  localparam logic [1:0] CELL_ROT = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [3:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [3:0]         element_index;
    logic [4:0]         length;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cell_op;
    logic       ld_out;
    logic [2:0] status;
    logic       elem_sel;
    logic       last;
    logic       k_clr;
    logic       k_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic full;
    logic empty;
    logic pos_bad;
    logic emit_last;
    logic ring_done;
  } dp_stat_t;

endpackage

// File: hdl/plid_ctrl.sv
// Controller state machine of the positional insert/delete list.
// Depends on plid_pkg; drives the datapath through dp_cmd_t.
module plid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         kind_i,
  output logic               in_stall_o,
  input  plid_pkg::dp_stat_t stat_i,
  output plid_pkg::dp_cmd_t  cmd_o
);
  import plid_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TRAV = 2'd1;
  localparam logic [1:0] S_ROT  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = !((state_q == S_IDLE) && stat_i.slot_free);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.cell_op  = CELL_NOP;
    cmd_o.status   = ST_DONE;
    cmd_o.last     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.slot_free) begin
          case (kind_i)
            KIND_INSERT: begin
              cmd_o.ld_out = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.cell_op = CELL_INS;
              end
            end
            KIND_DELETE: begin
              cmd_o.ld_out = 1'b1;
              if (stat_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else if (stat_i.pos_bad) begin
                cmd_o.status = ST_BADPOS;
              end else begin
                cmd_o.cell_op = CELL_DEL;
              end
            end
            KIND_TRAVERSE: begin
              if (stat_i.empty) begin
                cmd_o.ld_out = 1'b1;
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.k_clr = 1'b1;
                state_d     = S_TRAV;
              end
            end
            default: begin
              cmd_o.ld_out = 1'b1;
            end
          endcase
        end
      end
      S_TRAV: begin
        if (stat_i.slot_free) begin
          cmd_o.cell_op  = CELL_ROT;
          cmd_o.ld_out   = 1'b1;
          cmd_o.status   = ST_ELEM;
          cmd_o.elem_sel = 1'b1;
          cmd_o.last     = stat_i.emit_last;
          cmd_o.k_inc    = 1'b1;
          if (stat_i.emit_last) begin
            state_d = stat_i.ring_done ? S_IDLE : S_ROT;
          end
        end
      end
      S_ROT: begin
        cmd_o.cell_op = CELL_ROT;
        cmd_o.k_inc   = 1'b1;
        if (stat_i.ring_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/plid_datapath.sv
// Datapath of the positional insert/delete list: shifting cell row,
// entry count, traverse counter and output register. Depends on plid_pkg.
module plid_datapath #(
  parameter int Depth = plid_pkg::DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plid_pkg::in_item_t  in_i,
  input  plid_pkg::dp_cmd_t   cmd_i,
  output plid_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plid_pkg::out_item_t out_o
);
  import plid_pkg::*;

  localparam int CW = $clog2(Depth + 1);

  logic signed [31:0] cell_q [Depth];
  logic signed [31:0] cell_d [Depth];
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      k_q, k_d;
  logic [31:0]        count_w, pos_w, k_w, ins_pos, emit_n;
  logic               out_valid_q;
  out_item_t          out_q;

  assign count_w = 32'(count_q);
  assign pos_w   = 32'(in_i.position);
  assign k_w     = 32'(k_q);
  assign ins_pos = (pos_w > count_w) ? count_w : pos_w;
  assign emit_n  = (count_w > 32'(MaxResults)) ? 32'(MaxResults) : count_w;

  assign stat_o.slot_free = !out_valid_q || !out_stall_i;
  assign stat_o.full      = (count_w >= 32'(Depth));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.pos_bad   = (pos_w >= count_w);
  assign stat_o.emit_last = ((k_w + 32'd1) == emit_n);
  assign stat_o.ring_done = ((k_w + 32'd1) == count_w);

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < Depth; i++) begin
      cell_d[i] = cell_q[i];
    end
    case (cmd_i.cell_op)
      CELL_INS: begin
        count_d = count_q + CW'(1);
        for (int i = 0; i < Depth; i++) begin
          if (32'(i) == ins_pos) begin
            cell_d[i] = in_i.value;
          end else if ((i > 0) && (32'(i) > ins_pos)) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
      CELL_DEL: begin
        count_d = count_q - CW'(1);
        for (int i = 0; i < Depth - 1; i++) begin
          if (32'(i) >= pos_w) begin
            cell_d[i] = cell_q[i + 1];
          end
        end
      end
      CELL_ROT: begin
        // rotate the stored part of the row down by one
        for (int i = 0; i < Depth; i++) begin
          if ((32'(i) + 32'd1) == count_w) begin
            cell_d[i] = cell_q[0];
          end else if (i < Depth - 1) begin
            cell_d[i] = cell_q[(i < Depth - 1) ? i + 1 : i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.k_clr) begin
      k_d = '0;
    end else if (cmd_i.k_inc) begin
      k_d = k_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (cmd_i.ld_out) begin
      out_q.status        <= cmd_i.status;
      out_q.element       <= cmd_i.elem_sel ? cell_q[0] : 32'sd0;
      out_q.element_index <= cmd_i.elem_sel ? 4'(k_q) : 4'd0;
      out_q.length        <= 5'(count_d);
      out_q.last          <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      k_q     <= k_d;
      if (cmd_i.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: hdl/positional_insert_delete_list.sv
// Top level of the positional insert/delete list.
// Depends on plid_pkg, plid_ctrl, plid_datapath and assert_macros.svh.
//
// Usage:
// - Input channel (in_valid_i, in_stall_o, in_i) takes one command item:
//   insert, delete or traverse. Output channel (out_valid_o, out_stall_i,
//   out_o) returns result items, one per handshake.
// - Insert, delete and unused kinds: the cells shift in parallel at the
//   accepting edge and the single result item sits in the output register
//   on the next cycle; a new command is taken in the same cycle the result
//   leaves, so these run at one item per cycle unless the receiver stalls.
// - Traverse: the accepting cycle gives no item; then one element item per
//   cycle while the receiver does not stall, in order, with last on the
//   final one; at most 16 items. The row rotates by one per item, then on
//   its own back to its start, silently after the last item when the list
//   holds more than 16. An empty list gives one empty status item.
// - Input is stalled while a traverse runs and while a result waits.
// - Reset clears the entry count (empty list) and the output valid; the
//   cell contents are not cleared and need no clearing pass.
// - A stalled receiver holds the result in the output register and
//   freezes the emission of traverse items until the item is taken.
`include "assert_macros.svh"

module positional_insert_delete_list #(
  parameter int DEPTH = plid_pkg::DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plid_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plid_pkg::out_item_t out_o
);
  import plid_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_acc;

  // controller: sequences commands and traverse emission
  plid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_i.kind),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: cells, count, traverse counter, output register
  plid_datapath #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  assign in_acc = in_valid_i && !in_stall_o;

  // a non-traverse command yields its single, final result on the next cycle
  `PLID_ASSERT_NEXT(a_single_result, in_acc && (in_i.kind != KIND_TRAVERSE),
                    out_valid_o && out_o.last, "single result missing")
  // a waiting non-final element keeps the input blocked
  `PLID_ASSERT_SAME(a_trav_blocks,
                    out_valid_o && (out_o.status == ST_ELEM) && !out_o.last,
                    in_stall_o, "input accepted during traverse")
  // only element results can be non-final; status results carry a zero element
  `PLID_ASSERT_SAME(a_last_on_status, out_valid_o && (out_o.status != ST_ELEM),
                    out_o.last && (out_o.element == 32'sd0), "status result malformed")

endmodule

// File: bench/positional_insert_delete_list_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the positional insert/delete list block.
// Needs plid_pkg and the positional_insert_delete_list top level; nothing else.
module positional_insert_delete_list_tb;
  import plid_pkg::*;

  localparam int ListDepth  = DepthDef;
  localparam int RandItems  = 200;
  localparam int IdleLimit  = 4000;
  localparam int TailCycles = 24;
  localparam int ReportMax  = 10;

  // the package names kinds 0..2 only; the fourth encoding is a no-op
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // command mix of one random stretch
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_e;
  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_o;

  // commands waiting for the driver, and results the block still owes
  in_item_t  cmd_backlog[$];
  out_item_t due_results[$];

  // shadow copy of the list, advanced once per accepted command
  logic signed [31:0] shadow_entries [ListDepth];
  int                 shadow_count = 0;

  // entry count as the stimulus generator sees it, to aim delete positions
  int gen_count = 0;

  int fault_count = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  positional_insert_delete_list #(
    .DEPTH(ListDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_i       (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_o      (out_o)
  );

  // Advance the shadow list by one command and queue the items it must return.
  function automatic void apply_list_command(input in_item_t cmd);
    out_item_t res;
    int        slot;
    int        emit_n;
    res  = '0;
    slot = int'(cmd.position);
    res.last = 1'b1;
    case (cmd.kind)
      KIND_INSERT: begin
        if (shadow_count >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          // past the end means append
          if (slot > shadow_count) slot = shadow_count;
          for (int i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[slot] = cmd.value;
          shadow_count++;
          res.status = ST_DONE;
        end
        res.length = 5'(shadow_count);
        due_results.push_back(res);
      end
      KIND_DELETE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (slot >= shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = slot; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
          res.status = ST_DONE;
        end
        res.length = 5'(shadow_count);
        due_results.push_back(res);
      end
      KIND_TRAVERSE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
          res.length = 5'(shadow_count);
          due_results.push_back(res);
        end else begin
          // one element item per entry, capped at the result limit
          emit_n = (shadow_count > MaxResults) ? MaxResults : shadow_count;
          for (int i = 0; i < emit_n; i++) begin
            res.status        = ST_ELEM;
            res.element       = shadow_entries[i];
            res.element_index = 4'(i);
            res.length        = 5'(shadow_count);
            res.last          = (i + 1 == emit_n);
            due_results.push_back(res);
          end
        end
      end
      default: begin
        res.status = ST_DONE;
        res.length = 5'(shadow_count);
        due_results.push_back(res);
      end
    endcase
  endfunction

  // Queue one command for the driver and track the list length it leaves.
  task automatic queue_cmd(input logic [1:0] kind, input logic [31:0] value,
                           input logic [3:0] position);
    in_item_t cmd;
    cmd.kind     = kind;
    cmd.value    = value;
    cmd.position = position;
    cmd_backlog.push_back(cmd);
    if (kind == KIND_INSERT && gen_count < ListDepth) gen_count++;
    if (kind == KIND_DELETE && gen_count > 0 && int'(position) < gen_count) gen_count--;
  endtask

  // Mostly full-range random words, with the corner values now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Driver: predict on each accepted item, then present the next one or idle.
  // Change the payload only when nothing is held by a stall.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall_o) apply_list_command(in_item);
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= cmd_backlog.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // close the burst; a third of the time go straight into the next
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation,
  // then pick the stall for the next cycle from the current style.
  rx_mode_e rx_mode  = RX_OPEN;
  int       rx_left  = 0;
  int       rx_cycle = 0;

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (due_results.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportMax)
            $display("%0t: unexpected result st=%0d elem=%0d idx=%0d len=%0d last=%0b",
                     $realtime, out_o.status, out_o.element, out_o.element_index,
                     out_o.length, out_o.last);
        end else begin
          want = due_results.pop_front();
          if (out_o.status !== want.status || out_o.element !== want.element ||
              out_o.element_index !== want.element_index ||
              out_o.length !== want.length || out_o.last !== want.last) begin
            fault_count++;
            if (fault_count <= ReportMax)
              $display("%0t: mismatch exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                       $realtime, want.status, want.element, want.element_index,
                       want.length, want.last, out_o.status, out_o.element,
                       out_o.element_index, out_o.length, out_o.last);
          end
        end
      end

      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 80);
      end else begin
        rx_left--;
      end
      rx_cycle++;
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  // Watchdog: end the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("FAIL positional_insert_delete_list");
          $finish;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    mix_e       mix;
    int         mix_left;
    int         roll;
    logic [1:0] kind;
    logic [3:0] slot;
    mix      = MIX_BLEND;
    mix_left = 0;

    // Directed: empty list cases, the four insert placements, both delete
    // refusals, the unused kind, then fill to the top and traverse it all.
    queue_cmd(KIND_TRAVERSE, 32'h1234_5678, 4'd9);
    queue_cmd(KIND_DELETE,   32'h0,         4'd0);
    queue_cmd(KIND_INSERT,   32'h7FFF_FFFF, 4'd15);   // clamped onto empty list
    queue_cmd(KIND_INSERT,   32'h8000_0000, 4'd0);    // front
    queue_cmd(KIND_INSERT,   32'hFFFF_FFFF, 4'd1);    // middle
    queue_cmd(KIND_INSERT,   32'h0000_0000, 4'd15);   // past the end, appended
    queue_cmd(KIND_TRAVERSE, 32'hFFFF_FFFF, 4'd15);
    queue_cmd(KIND_DELETE,   32'hFFFF_FFFF, 4'd4);    // index equal to length
    queue_cmd(KIND_DELETE,   32'h0,         4'd1);
    queue_cmd(KIND_UNUSED,   32'hA5A5_A5A5, 4'd10);
    while (gen_count < ListDepth)
      queue_cmd(KIND_INSERT, pick_value(), 4'($urandom_range(0, 15)));
    queue_cmd(KIND_INSERT,   32'h5555_5555, 4'd3);    // refused, list full
    queue_cmd(KIND_TRAVERSE, 32'h0,         4'd0);    // longest traverse
    queue_cmd(KIND_DELETE,   32'h0,         4'd15);   // drop the tail entry

    // Random: stretches biased to fill, drain or mix, so the list swings
    // between empty and full; delete positions mostly aim inside the list.
    repeat (RandItems) begin
      if (mix_left == 0) begin
        mix      = mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(8, 30);
      end
      mix_left--;
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  kind = (roll < 75) ? KIND_INSERT : (roll < 87) ? KIND_TRAVERSE :
                          (roll < 97) ? KIND_DELETE : KIND_UNUSED;
        MIX_DRAIN: kind = (roll < 70) ? KIND_DELETE : (roll < 85) ? KIND_TRAVERSE :
                          (roll < 97) ? KIND_INSERT : KIND_UNUSED;
        default:   kind = (roll < 40) ? KIND_INSERT : (roll < 75) ? KIND_DELETE :
                          (roll < 95) ? KIND_TRAVERSE : KIND_UNUSED;
      endcase
      if (kind == KIND_DELETE && gen_count > 0 && $urandom_range(0, 9) < 8)
        slot = 4'($urandom_range(0, gen_count - 1));
      else
        slot = 4'($urandom_range(0, 15));
      queue_cmd(kind, pick_value(), slot);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every command taken, every result back, then let the block settle.
    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (due_results.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("PASS positional_insert_delete_list");
    end else begin
      $display("FAIL positional_insert_delete_list");
    end
    $finish;
  end

endmodule
